FILE: rtl/core/vtp_pkg.sv
// ============================================================================
// vtp_pkg
// Shared types, constants and helpers for the vertex transform pipeline.
// ============================================================================
`default_nettype none

package vtp_pkg;

    // Default number of fraction bits of the fixed-point format.
    localparam int unsigned FRAC_BITS_DEF = 16;

    // Request codes.
    localparam logic REQ_LOAD      = 1'b0;
    localparam logic REQ_TRANSFORM = 1'b1;

    // Per-item flags that travel down the pipeline beside the data.
    typedef struct packed {
        logic bypass;
        logic sat;
        logic wzero;
    } t_ctl;

    // One finished result.
    typedef struct packed {
        logic [31:0] rx;
        logic [31:0] ry;
        logic [31:0] rz;
        logic [31:0] rw;
        logic        bypassed;
        logic        saturated;
    } t_res;

    // Sign-extend a 32-bit word to 64 bits.
    function automatic logic signed [63:0] sx64(input logic [31:0] v);
        return $signed({{32{v[31]}}, v});
    endfunction

    // Magnitude of a signed 32-bit word; the most negative value maps to 2^31.
    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/vertex_transform_perspective_top.sv
// Throughput: one request per cycle while o_stall is low; each of the 32 + FRAC_BITS divide stages
// yields one quotient bit, and all stages work on different points at once.
// A load request writes the matrix at acceptance and gives no result.
// Reset (synchronous, active low) empties the pipeline and loads the identity matrix.
// ============================================================================
// vertex_transform_perspective_top
// 4x4 fixed-point vertex transform with perspective divide.
// ============================================================================
`default_nettype none

module vertex_transform_perspective_top import vtp_pkg::*; #(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_req_type,
    input  wire logic [3:0]  i_entry_index,
    input  wire logic [31:0] i_entry_value,
    input  wire logic [31:0] i_px,
    input  wire logic [31:0] i_py,
    input  wire logic [31:0] i_pz,
    input  wire logic [31:0] i_pw,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_rx,
    output logic [31:0]      o_ry,
    output logic [31:0]      o_rz,
    output logic [31:0]      o_rw,
    output logic             o_bypassed,
    output logic             o_saturated
);

    localparam logic [31:0] C_ONE = 32'd1 << FRAC_BITS;

    logic [31:0] r_mat [0:15];
    logic [31:0] w_mat [0:15];
    logic [31:0] w_pt  [0:3];
    logic        w_en;
    logic        w_acc;
    logic        w_dv;
    t_ctl        w_ctl;
    logic [31:0] w_val [0:3];
    logic        w_uv;
    t_res        w_ures;
    logic        r_out_v, r_skid_v;
    t_res        r_out, r_skid;

    assign w_en  = !r_skid_v;
    assign w_acc = i_valid && w_en;
    assign w_pt[0] = i_px;
    assign w_pt[1] = i_py;
    assign w_pt[2] = i_pz;
    assign w_pt[3] = i_pw;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            w_mat[i] = r_mat[i];
        end
    end

    // Matrix store: load requests write one entry at acceptance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_mat[i] <= (i[3:2] == i[1:0]) ? C_ONE : 32'd0;
            end
        end else if (w_acc && (i_req_type == REQ_LOAD)) begin
            r_mat[i_entry_index] <= i_entry_value;
        end
    end

    vtp_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_acc && (i_req_type == REQ_TRANSFORM)),
        .i_mat   (w_mat),
        .i_pt    (w_pt),
        .o_valid (w_dv),
        .o_ctl   (w_ctl),
        .o_val   (w_val)
    );

    vtp_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dv),
        .i_ctl   (w_ctl),
        .i_val   (w_val),
        .o_valid (w_uv),
        .o_res   (w_ures)
    );

    // Output register with a skid stage; the pipeline freezes only when the skid is full.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_skid_v) begin
            if (r_out_v && i_stall) begin
                if (w_uv) begin
                    r_skid_v <= 1'b1;
                end
            end else begin
                r_out_v <= w_uv;
            end
        end else if (!i_stall) begin
            r_skid_v <= 1'b0;
            r_out_v  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            if (r_out_v && i_stall) begin
                r_skid <= w_ures;
            end else begin
                r_out <= w_ures;
            end
        end else if (!i_stall) begin
            r_out <= r_skid;
        end
    end

    assign o_stall     = r_skid_v;
    assign o_valid     = r_out_v;
    assign o_rx        = r_out.rx;
    assign o_ry        = r_out.ry;
    assign o_rz        = r_out.rz;
    assign o_rw        = r_out.rw;
    assign o_bypassed  = r_out.bypassed;
    assign o_saturated = r_out.saturated;

    // The skid stage only fills behind a full output register.
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid stage full while output register empty");

    // A bypassed point never reports saturation.
    a_bypass_nosat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bypassed) |-> !o_saturated)
        else $error("bypassed result flagged as saturated");

    // A transformed point leaves with w equal to one or zero.
    a_w_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_bypassed) |-> (o_rw == C_ONE || o_rw == 32'd0))
        else $error("transformed w is neither one nor zero");

    // Reset empties the output side.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("output not empty after reset");

endmodule

`default_nettype wire

FILE: rtl/core/vtp_dot.sv
// ============================================================================
// vtp_dot
// Four row dot products: multiply, two adder levels, then floor shift,
// saturation and the negative-z bypass select.
// ============================================================================
`default_nettype none

module vtp_dot import vtp_pkg::*; #(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [31:0] i_mat [0:15],
    input  wire logic [31:0] i_pt  [0:3],
    output logic             o_valid,
    output t_ctl             o_ctl,
    output logic [31:0]      o_val [0:3]
);

    logic               r_v1, r_v2, r_v3, r_v4;
    logic               r_byp1, r_byp2, r_byp3;
    logic signed [63:0] r_p   [0:15];
    logic signed [64:0] r_s2  [0:7];
    logic signed [65:0] r_s3  [0:3];
    logic [31:0]        r_pt1 [0:3];
    logic [31:0]        r_pt2 [0:3];
    logic [31:0]        r_pt3 [0:3];
    t_ctl               r_ctl4;
    logic [31:0]        r_val4 [0:3];

    logic signed [65:0] n_sh  [0:3];
    logic [3:0]         n_ovf;
    logic [31:0]        n_val [0:3];
    t_ctl               n_ctl;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Floor shift, saturate each row, and pick the input point on bypass.
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            n_sh[r]  = r_s3[r] >>> FRAC_BITS;
            n_ovf[r] = !((&n_sh[r][65:31]) || !(|n_sh[r][65:31]));
            if (n_ovf[r]) begin
                n_val[r] = n_sh[r][65] ? 32'h8000_0000 : 32'h7fff_ffff;
            end else begin
                n_val[r] = n_sh[r][31:0];
            end
            if (r_byp3) begin
                n_val[r] = r_pt3[r];
            end
        end
        n_ctl.bypass = r_byp3;
        n_ctl.sat    = !r_byp3 && (|n_ovf);
        n_ctl.wzero  = !r_byp3 && (n_val[3] == 32'd0);
    end

    // Datapath stages: products, pair sums, row sums, scaled rows.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 16; i++) begin
                r_p[i] <= sx64(i_mat[i]) * sx64(i_pt[i % 4]);
            end
            for (int i = 0; i < 8; i++) begin
                r_s2[i] <= {r_p[2*i][63], r_p[2*i]} + {r_p[2*i+1][63], r_p[2*i+1]};
            end
            for (int i = 0; i < 4; i++) begin
                r_s3[i] <= {r_s2[2*i][64], r_s2[2*i]} + {r_s2[2*i+1][64], r_s2[2*i+1]};
                r_pt1[i] <= i_pt[i];
                r_pt2[i] <= r_pt1[i];
                r_pt3[i] <= r_pt2[i];
                r_val4[i] <= n_val[i];
            end
            r_byp1 <= i_pt[2][31];
            r_byp2 <= r_byp1;
            r_byp3 <= r_byp2;
            r_ctl4 <= n_ctl;
        end
    end

    assign o_valid = r_v4;
    assign o_ctl   = r_ctl4;
    assign o_val   = r_val4;

endmodule

`default_nettype wire

FILE: rtl/core/vtp_divider.sv
// ============================================================================
// vtp_divider
// Perspective divide: three restoring dividers, one quotient bit per stage,
// sharing the divisor, followed by sign fix-up and saturation.
// ============================================================================
`default_nettype none

module vtp_divider import vtp_pkg::*; #(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire t_ctl        i_ctl,
    input  wire logic [31:0] i_val [0:3],
    output logic             o_valid,
    output t_res             o_res
);

    localparam int unsigned NW = 32 + FRAC_BITS;

    logic          r_v   [0:NW];
    t_ctl          r_c   [0:NW];
    logic [31:0]   r_d   [0:NW];
    logic [31:0]   r_val [0:NW][0:3];
    logic          r_neg [0:NW][0:2];
    logic [NW-1:0] r_num [0:NW][0:2];
    logic [31:0]   r_rem [0:NW][0:2];
    logic [NW-1:0] r_q   [0:NW][0:2];
    logic          r_ov;
    t_res          r_res;

    logic [32:0]   n_t   [1:NW][0:2];
    logic          n_ge  [1:NW][0:2];
    logic [31:0]   n_rem [1:NW][0:2];
    logic [31:0]   n_quo [0:2];
    logic [2:0]    n_ovf;
    t_res          n_res;

    // One restoring step per stage and lane.
    always_comb begin
        for (int k = 1; k <= NW; k++) begin
            for (int l = 0; l < 3; l++) begin
                n_t[k][l]  = {r_rem[k-1][l], r_num[k-1][l][NW-1]};
                n_ge[k][l] = n_t[k][l] >= {1'b0, r_d[k-1]};
                n_rem[k][l] = n_ge[k][l] ? 32'(n_t[k][l] - {1'b0, r_d[k-1]})
                                         : n_t[k][l][31:0];
            end
        end
    end

    // Sign fix-up, saturation and final select.
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (r_neg[NW][l]) begin
                n_ovf[l] = (|r_q[NW][l][NW-1:32])
                           || (r_q[NW][l][31] && (|r_q[NW][l][30:0]));
                n_quo[l] = n_ovf[l] ? 32'h8000_0000 : (32'd0 - r_q[NW][l][31:0]);
            end else begin
                n_ovf[l] = |r_q[NW][l][NW-1:31];
                n_quo[l] = n_ovf[l] ? 32'h7fff_ffff : r_q[NW][l][31:0];
            end
        end
        if (r_c[NW].bypass || r_c[NW].wzero) begin
            n_res.rx = r_val[NW][0];
            n_res.ry = r_val[NW][1];
            n_res.rz = r_val[NW][2];
            n_res.rw = r_val[NW][3];
            n_res.saturated = r_c[NW].sat;
        end else begin
            n_res.rx = n_quo[0];
            n_res.ry = n_quo[1];
            n_res.rz = n_quo[2];
            n_res.rw = 32'd1 << FRAC_BITS;
            n_res.saturated = r_c[NW].sat || (|n_ovf);
        end
        n_res.bypassed = r_c[NW].bypass;
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NW; k++) begin
                r_v[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= NW; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_ov <= r_v[NW];
        end
    end

    // Setup stage, divide stages and the result register.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c[0] <= i_ctl;
            r_d[0] <= mag32(i_val[3]);
            for (int i = 0; i < 4; i++) begin
                r_val[0][i] <= i_val[i];
            end
            for (int l = 0; l < 3; l++) begin
                r_neg[0][l] <= i_val[l][31] ^ i_val[3][31];
                r_num[0][l] <= {mag32(i_val[l]), {FRAC_BITS{1'b0}}};
                r_rem[0][l] <= '0;
                r_q[0][l]   <= '0;
            end
            for (int k = 1; k <= NW; k++) begin
                r_c[k] <= r_c[k-1];
                r_d[k] <= r_d[k-1];
                for (int i = 0; i < 4; i++) begin
                    r_val[k][i] <= r_val[k-1][i];
                end
                for (int l = 0; l < 3; l++) begin
                    r_neg[k][l] <= r_neg[k-1][l];
                    r_num[k][l] <= {r_num[k-1][l][NW-2:0], 1'b0};
                    r_rem[k][l] <= n_rem[k][l];
                    r_q[k][l]   <= {r_q[k-1][l][NW-2:0], n_ge[k][l]};
                end
            end
            r_res <= n_res;
        end
    end

    assign o_valid = r_ov;
    assign o_res   = r_res;

endmodule

`default_nettype wire
